FILE: rtl/core/rbd_pkg.sv
// Shared types and constants of the record block decompressor.
// No dependencies; imported by every module of the core.
package rbd_pkg;

	// configuration register indexes
	localparam logic [1:0] CFG_RECORD_MODE        = 2'd0;
	localparam logic [1:0] CFG_RECORD_SIZE        = 2'd1;
	localparam logic [1:0] CFG_RECORDS_PER_BLOCK  = 2'd2;
	localparam logic [1:0] CFG_LAST_BLOCK_RECORDS = 2'd3;

	// record modes
	localparam logic [1:0] MODE_FIXED = 2'd0;
	localparam logic [1:0] MODE_PRINT = 2'd2;

	localparam logic [7:0] CH_BLANK     = 8'h20;
	localparam logic [7:0] CH_FORMFEED  = 8'h0c;
	localparam logic [7:0] CH_PAGE_CODE = 8'h80;
	localparam logic [7:0] CH_GRAPH_LO  = 8'h21;
	localparam logic [7:0] CH_GRAPH_HI  = 8'h7e;
	localparam logic [7:0] REP_MASK     = 8'h7f;

	// result queue
	localparam int RES_DEPTH = 4;
	localparam int RES_PTR_W = 2;
	localparam int RES_CNT_W = 3;
	localparam int MAX_RES   = 3;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_BHI,
		PH_BLO,
		PH_RHI,
		PH_RLO,
		PH_BODY,
		PH_FIX
	} phase_t;

	typedef enum logic [1:0] {
		CS_SCAN,
		CS_REP,
		CS_LIT
	} code_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic [11:0] run_length;
		logic        end_of_record;
		logic        overflow;
	} res_t;

	// results of one item, packed from index 0
	typedef struct packed {
		logic [1:0]        n;
		res_t [MAX_RES-1:0] r;
	} res_bundle_t;

	function automatic logic [7:0] map_byte(input logic [7:0] b, input logic [1:0] mode);
		logic [7:0] m;
		m = b;
		if (mode == MODE_PRINT) begin
			if (b == CH_PAGE_CODE) begin
				m = CH_FORMFEED;
			end else if (!(b >= CH_GRAPH_LO && b <= CH_GRAPH_HI)) begin
				m = CH_BLANK;
			end
		end
		return m;
	endfunction

endpackage

FILE: rtl/core/rbd_decode.sv
// Parser and run-length expander: state registers plus the per-item update.
// Depends on rbd_pkg; produces the results of one item as a res_bundle_t.
module rbd_decode #(
	parameter int BLOCK_BYTES     = 2048,
	parameter int RECORD_CAPACITY = 2048
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic [7:0]         data_byte,
	input  logic               block_start,
	input  logic               final_block,
	input  logic [1:0]         record_mode,
	input  logic [11:0]        record_size,
	input  logic [11:0]        records_per_block,
	input  logic [11:0]        last_block_records,
	output rbd_pkg::res_bundle_t res
);
	import rbd_pkg::*;

	localparam int CAP_W = $clog2(RECORD_CAPACITY + 1);
	localparam int LW    = (CAP_W > 12) ? CAP_W : 12;
	localparam int PW    = $clog2(BLOCK_BYTES + 1);

	typedef struct packed {
		logic          v;
		res_t          r;
	} slot_t;

	typedef struct packed {
		logic [LW-1:0] rlo;
		logic [LW-1:0] pb;
		logic          ov;
		logic          vb;
		logic [11:0]   lenb;
		logic          vc;
		logic [7:0]    bytec;
		logic [11:0]   lenc;
	} pc_t;

	// one character run into the record: blank trimming and capacity clip
	function automatic pc_t put_char(input logic [LW-1:0] rlo, input logic [LW-1:0] pb,
		input logic ov, input logic [7:0] b, input logic [7:0] k_in, input logic capped,
		input logic [1:0] mode);
		pc_t p;
		logic [LW-1:0] k;
		logic [LW-1:0] room;
		p.rlo   = rlo;
		p.pb    = pb;
		p.ov    = ov;
		p.vb    = 1'b0;
		p.lenb  = '0;
		p.vc    = 1'b0;
		p.bytec = '0;
		p.lenc  = '0;
		k    = LW'(k_in);
		room = LW'(RECORD_CAPACITY) - rlo;
		if (capped) begin
			if (rlo >= LW'(RECORD_CAPACITY)) begin
				p.ov = 1'b1;
				k    = '0;
			end else if (k > room) begin
				k    = room;
				p.ov = 1'b1;
			end
		end
		if (k != '0) begin
			if (b == CH_BLANK) begin
				if (rlo == '0) begin
					// first character of a record is always sent
					p.vc    = 1'b1;
					p.bytec = map_byte(b, mode);
					p.lenc  = 12'd1;
					p.pb    = pb + k - LW'(1);
				end else begin
					p.pb = pb + k;
				end
			end else begin
				if (pb != '0) begin
					p.vb   = 1'b1;
					p.lenb = pb[11:0];
					p.pb   = '0;
				end
				p.vc    = 1'b1;
				p.bytec = map_byte(b, mode);
				p.lenc  = k[11:0];
			end
			p.rlo = rlo + k;
		end
		return p;
	endfunction

	function automatic res_t end_res(input logic ov);
		res_t r;
		r.out_byte      = '0;
		r.run_length    = '0;
		r.end_of_record = 1'b1;
		r.overflow      = ov;
		return r;
	endfunction

	phase_t         phase_q;
	logic [PW-1:0]  pos_q;
	logic [15:0]    blen_q;
	logic [15:0]    brem_q;
	code_t          cs_q;
	logic [7:0]     lit_q;
	logic [7:0]     rep_q;
	logic [LW-1:0]  rlo_q;
	logic [LW-1:0]  pb_q;
	logic [11:0]    ridx_q;
	logic [11:0]    bir_q;
	logic           ov_q;

	phase_t         ph;
	logic [PW-1:0]  pos;
	logic [15:0]    blen;
	logic [15:0]    brem;
	code_t          cs;
	logic [7:0]     lit;
	logic [7:0]     rep;
	logic [LW-1:0]  rlo;
	logic [LW-1:0]  pb;
	logic [11:0]    ridx;
	logic [11:0]    bir;
	logic           ov;
	slot_t [3:0]    slot;

	always_comb begin
		logic        adv;
		logic [11:0] rs;
		logic [15:0] h;
		pc_t         pc;
		ph   = phase_q;
		pos  = pos_q;
		blen = blen_q;
		brem = brem_q;
		cs   = cs_q;
		lit  = lit_q;
		rep  = rep_q;
		rlo  = rlo_q;
		pb   = pb_q;
		ridx = ridx_q;
		bir  = bir_q;
		ov   = ov_q;
		slot = '0;
		adv  = 1'b1;
		pc   = '0;
		h    = '0;
		rs   = (record_size == '0) ? 12'd1 : record_size;

		// slot 0: close of a record cut by an early block start
		if (block_start) begin
			if ((ph == PH_FIX && bir != '0) || ph == PH_BODY) begin
				slot[0].v = 1'b1;
				slot[0].r = end_res(ov);
			end
			rlo  = '0;
			pb   = '0;
			ov   = 1'b0;
			cs   = CS_SCAN;
			lit  = '0;
			rep  = '0;
			pos  = '0;
			blen = '0;
			brem = '0;
			ridx = '0;
			bir  = '0;
			ph   = (record_mode == MODE_FIXED) ? PH_FIX : PH_BHI;
		end

		// slots 1 and 2: blank run and character run; slot 3: record end
		unique case (ph)
			PH_IDLE: adv = 1'b0;
			PH_FIX: begin
				if (bir == '0 && !(ridx < records_per_block &&
						!(final_block && ridx >= last_block_records))) begin
					ph  = PH_IDLE;
					adv = 1'b0;
				end else begin
					pc = put_char(rlo, pb, ov, data_byte, 8'd1, 1'b0, record_mode);
					rlo = pc.rlo;
					pb  = pc.pb;
					ov  = pc.ov;
					slot[1] = '{v: pc.vb, r: '{CH_BLANK, pc.lenb, 1'b0, 1'b0}};
					slot[2] = '{v: pc.vc, r: '{pc.bytec, pc.lenc, 1'b0, 1'b0}};
					bir = bir + 12'd1;
					if (bir >= rs) begin
						slot[3].v = 1'b1;
						slot[3].r = end_res(ov);
						rlo  = '0;
						pb   = '0;
						ov   = 1'b0;
						cs   = CS_SCAN;
						lit  = '0;
						rep  = '0;
						ridx = ridx + 12'd1;
						bir  = '0;
					end
				end
			end
			PH_BHI: begin
				blen = {data_byte, 8'h00};
				ph   = PH_BLO;
			end
			PH_BLO: begin
				blen[7:0] = data_byte;
				ph        = PH_RHI;
			end
			PH_RHI: begin
				if (32'(pos) >= 32'(blen)) begin
					ph  = PH_IDLE;
					adv = 1'b0;
				end else begin
					brem = {data_byte, 8'h00};
					ph   = PH_RLO;
				end
			end
			PH_RLO: begin
				h   = brem | {8'h00, data_byte};
				rlo = '0;
				pb  = '0;
				ov  = 1'b0;
				cs  = CS_SCAN;
				lit = '0;
				rep = '0;
				if (h < 16'd2) begin
					// short header: empty record
					brem      = '0;
					slot[3].v = 1'b1;
					slot[3].r = end_res(1'b0);
					ph        = PH_RHI;
				end else begin
					brem = h - 16'd2;
					if (brem == '0) begin
						slot[3].v = 1'b1;
						slot[3].r = end_res(1'b0);
						ph        = PH_RHI;
					end else begin
						ph = PH_BODY;
					end
				end
			end
			PH_BODY: begin
				case (cs)
					CS_SCAN: begin
						if (data_byte[7]) begin
							rep = (data_byte & REP_MASK) + 8'd1;
							cs  = CS_REP;
						end else begin
							lit = data_byte + 8'd1;
							cs  = CS_LIT;
						end
					end
					CS_REP: begin
						pc = put_char(rlo, pb, ov, data_byte, rep, 1'b1, record_mode);
						cs = CS_SCAN;
					end
					default: begin
						pc = put_char(rlo, pb, ov, data_byte, 8'd1, 1'b1, record_mode);
						if (lit != '0) begin
							lit = lit - 8'd1;
						end
						if (lit == '0) begin
							cs = CS_SCAN;
						end
					end
				endcase
				if (cs_q != CS_SCAN || block_start) begin
					if (cs_q != CS_SCAN && !block_start) begin
						rlo = pc.rlo;
						pb  = pc.pb;
						ov  = pc.ov;
						slot[1] = '{v: pc.vb, r: '{CH_BLANK, pc.lenb, 1'b0, 1'b0}};
						slot[2] = '{v: pc.vc, r: '{pc.bytec, pc.lenc, 1'b0, 1'b0}};
					end
				end
				brem = brem - 16'd1;
				if (brem == '0) begin
					slot[3].v = 1'b1;
					slot[3].r = end_res(ov);
					rlo = '0;
					pb  = '0;
					ov  = 1'b0;
					cs  = CS_SCAN;
					lit = '0;
					rep = '0;
					ph  = PH_RHI;
				end
			end
			default: begin
				ph  = PH_IDLE;
				adv = 1'b0;
			end
		endcase

		if (adv) begin
			pos = pos + PW'(1);
			if (32'(pos) >= BLOCK_BYTES) begin
				if ((ph == PH_FIX && bir != '0) || ph == PH_BODY) begin
					slot[3].v = 1'b1;
					slot[3].r = end_res(ov);
				end
				rlo = '0;
				pb  = '0;
				ov  = 1'b0;
				cs  = CS_SCAN;
				lit = '0;
				rep = '0;
				ph  = PH_IDLE;
			end
		end
	end

	// pack the occupied slots in order
	always_comb begin
		res = '0;
		for (int i = 0; i < 4; i++) begin
			if (slot[i].v && res.n != 2'd3) begin
				res.r[res.n] = slot[i].r;
				res.n        = res.n + 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pos_q   <= '0;
			blen_q  <= '0;
			brem_q  <= '0;
			cs_q    <= CS_SCAN;
			lit_q   <= '0;
			rep_q   <= '0;
			rlo_q   <= '0;
			pb_q    <= '0;
			ridx_q  <= '0;
			bir_q   <= '0;
			ov_q    <= 1'b0;
		end else if (en) begin
			phase_q <= ph;
			pos_q   <= pos;
			blen_q  <= blen;
			brem_q  <= brem;
			cs_q    <= cs;
			lit_q   <= lit;
			rep_q   <= rep;
			rlo_q   <= rlo;
			pb_q    <= pb;
			ridx_q  <= ridx;
			bir_q   <= bir;
			ov_q    <= ov;
		end
	end

endmodule

FILE: rtl/core/rbd_res_fifo.sv
// Result queue: takes up to three results of one item per cycle, gives one.
// Depends on rbd_pkg for res_t, res_bundle_t and the queue sizes.
module rbd_res_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  rbd_pkg::res_bundle_t wr,
	output logic                 room,
	output logic                 out_valid,
	input  logic                 out_ready,
	output rbd_pkg::res_t        head
);
	import rbd_pkg::*;

	res_t [RES_DEPTH-1:0]   mem_q;
	logic [RES_PTR_W-1:0]   wr_ptr_q;
	logic [RES_PTR_W-1:0]   rd_ptr_q;
	logic [RES_CNT_W-1:0]   count_q;
	logic [RES_PTR_W-1:0]   wa [MAX_RES];
	logic [RES_CNT_W-1:0]   n_push;
	logic                   pop;

	assign room      = count_q <= RES_CNT_W'(RES_DEPTH - MAX_RES);
	assign out_valid = count_q != '0;
	assign head      = mem_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;
	assign n_push    = push ? RES_CNT_W'(wr.n) : '0;

	always_comb begin
		for (int i = 0; i < MAX_RES; i++) begin
			wa[i] = wr_ptr_q + RES_PTR_W'(i);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RES; i++) begin
			if (push && RES_CNT_W'(i) < n_push) begin
				mem_q[wa[i]] <= wr.r[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_push[RES_PTR_W-1:0];
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + RES_PTR_W'(1);
			end
			count_q <= count_q + n_push - RES_CNT_W'(pop);
		end
	end

endmodule

FILE: rtl/core/record_block_decompressor_core.sv
// Top level of the record block decompressor: configuration registers,
// input register and wiring of rbd_decode and rbd_res_fifo (uses rbd_pkg).
//
// Block bytes enter one per cycle, while in_ready is high, through an input
// register; the parser and run-length expander update their counters in the
// same cycle and write the zero to three results of the byte into a
// four-entry result queue. A byte is taken from the input register whenever
// at most one result waits in the queue. The output side drains one result
// per cycle while out_ready is high, so a stream that gives one result per
// byte runs at one byte per cycle. No clearing pass after reset.
module record_block_decompressor_core #(
	parameter int BLOCK_BYTES     = 2048,
	parameter int RECORD_CAPACITY = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        block_start,
	input  logic        final_block,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic [11:0] run_length,
	output logic        end_of_record,
	output logic        overflow,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data
);
	import rbd_pkg::*;

	logic [1:0]  record_mode_q;
	logic [11:0] record_size_q;
	logic [11:0] records_per_block_q;
	logic [11:0] last_block_records_q;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        bs_s1;
	logic        fb_s1;
	logic        fire_s1;
	logic        room;
	res_bundle_t res;
	res_t        head;

	assign cfg_ready = 1'b1;
	assign fire_s1   = valid_s1 && room;
	assign in_ready  = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			record_mode_q        <= MODE_FIXED;
			record_size_q        <= 12'd80;
			records_per_block_q  <= 12'd25;
			last_block_records_q <= 12'd0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_RECORD_MODE:        record_mode_q        <= cfg_data[1:0];
				CFG_RECORD_SIZE:        record_size_q        <= cfg_data;
				CFG_RECORDS_PER_BLOCK:  records_per_block_q  <= cfg_data;
				CFG_LAST_BLOCK_RECORDS: last_block_records_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
			bs_s1   <= block_start;
			fb_s1   <= final_block;
		end
	end

	rbd_decode #(
		.BLOCK_BYTES    (BLOCK_BYTES),
		.RECORD_CAPACITY(RECORD_CAPACITY)
	) u_decode (
		.clk               (clk),
		.arst_n            (arst_n),
		.en                (fire_s1),
		.data_byte         (byte_s1),
		.block_start       (bs_s1),
		.final_block       (fb_s1),
		.record_mode       (record_mode_q),
		.record_size       (record_size_q),
		.records_per_block (records_per_block_q),
		.last_block_records(last_block_records_q),
		.res               (res)
	);

	rbd_res_fifo u_res_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (fire_s1),
		.wr       (res),
		.room     (room),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.head     (head)
	);

	assign out_byte      = head.out_byte;
	assign run_length    = head.run_length;
	assign end_of_record = head.end_of_record;
	assign overflow      = head.overflow;

endmodule
